// ===== sv/pba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and codes of the page bitmap allocator: request/result codes,
// controller states, scan pass modes and the command/status bundles.
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int ADDR_W = 32;
	localparam int SIZE_W = 17;
	localparam int STAT_W = 3;

	// result codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_SLOT  = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_PAGES = 3'd2;
	localparam logic [STAT_W-1:0] ST_ZERO     = 3'd3;
	localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd4;

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [2:0] {
		PASS_CLEAR,
		PASS_FIND,
		PASS_MATCH,
		PASS_CLAIM,
		PASS_RELEASE
	} pass_mode_t;

	typedef enum logic [3:0] {
		S_RESET,
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_FIND,
		S_CLAIM,
		S_MATCH,
		S_RELEASE,
		S_COMMIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              capture;
		logic              pass_start;
		pass_mode_t        mode;
		logic              region_write;
		logic              region_used;
		logic              load_out;
		logic [STAT_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic pass_done;
		logic slot_found;
		logic pages_ok;
		logic req_free;
		logic req_zero;
	} stat_t;

endpackage

// ===== sv/page_bitmap_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core
// Allocates and frees regions of PAGE_BYTES-sized pages from PAGE_COUNT pages.
//
// Requests arrive on in_valid/in_stall with kind, byte_size and free_address;
// a beat is taken when in_valid is high and in_stall low. Each request gives
// one result beat on out_valid/out_stall with region_address and status.
// User must write base_address via cfg_we/cfg_wdata when idle (not enforced).
//
// One request at a time. Each scan pass walks max(PAGE_COUNT, REGION_COUNT)
// table entries, one per cycle through the single read port of each table,
// plus its read and update stages. An allocate runs a slot/free count pass
// and a claim pass; its result beat rises as the block turns idle again and
// can take the next request. A free runs a match pass and a release pass,
// the same length. A rejected request skips the second pass; a zero-size
// allocate runs no pass.
//
// After reset both tables are cleared, one entry per cycle, with in_stall
// high. A stalled result waits in the output register; the next request is
// taken meanwhile and its result waits until that register frees.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_core #(
	parameter int PAGE_COUNT   = 64,
	parameter int PAGE_BYTES   = 1024,
	parameter int REGION_COUNT = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pba_pkg::ADDR_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [pba_pkg::SIZE_W-1:0] byte_size,
	input  logic [pba_pkg::ADDR_W-1:0] free_address,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [pba_pkg::ADDR_W-1:0] region_address,
	output logic [pba_pkg::STAT_W-1:0] status
);
	import pba_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	pba_datapath #(
		.PAGE_COUNT   (PAGE_COUNT),
		.PAGE_BYTES   (PAGE_BYTES),
		.REGION_COUNT (REGION_COUNT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.kind           (kind),
		.byte_size      (byte_size),
		.free_address   (free_address),
		.region_address (region_address),
		.status         (status),
		.cmd            (cmd),
		.stat           (stat)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request beat taken while a request is in flight");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (region_address == '0))
		else $error("failed result carries a nonzero address");

	a_commit_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.region_write |-> stat.slot_found)
		else $error("region table written without a chosen slot");

	a_pass_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pass_start |-> in_stall)
		else $error("scan pass started while accepting requests");

endmodule

// ===== sv/pba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_ctrl
// Request sequencer: runs the scan passes of an allocate or a free in order,
// picks the result code and owns the input stall and the output beat valid.
// ----------------------------------------------------------------------------
module pba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output pba_pkg::cmd_t  cmd,
	input  pba_pkg::stat_t stat
);
	import pba_pkg::*;

	state_t            state_q, state_d;
	logic [STAT_W-1:0] res_q, res_d;
	logic              out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RESET;
			res_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_q       <= res_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_RESET: begin
				cmd.pass_start = 1'b1;
				cmd.mode       = PASS_CLEAR;
				state_d        = S_CLEAR;
			end
			S_CLEAR: begin
				if (stat.pass_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (stat.req_free) begin
					cmd.pass_start = 1'b1;
					cmd.mode       = PASS_MATCH;
					state_d        = S_MATCH;
				end else if (stat.req_zero) begin
					res_d   = ST_ZERO;
					state_d = S_DONE;
				end else begin
					cmd.pass_start = 1'b1;
					cmd.mode       = PASS_FIND;
					state_d        = S_FIND;
				end
			end
			S_FIND: begin
				if (stat.pass_done) begin
					priority if (!stat.slot_found) begin
						res_d   = ST_NO_SLOT;
						state_d = S_DONE;
					end else if (!stat.pages_ok) begin
						res_d   = ST_NO_PAGES;
						state_d = S_DONE;
					end else begin
						cmd.pass_start = 1'b1;
						cmd.mode       = PASS_CLAIM;
						state_d        = S_CLAIM;
					end
				end
			end
			S_CLAIM: begin
				if (stat.pass_done) state_d = S_COMMIT;
			end
			S_MATCH: begin
				if (stat.pass_done) begin
					if (!stat.slot_found) begin
						res_d   = ST_UNKNOWN;
						state_d = S_DONE;
					end else begin
						cmd.pass_start = 1'b1;
						cmd.mode       = PASS_RELEASE;
						state_d        = S_RELEASE;
					end
				end
			end
			S_RELEASE: begin
				if (stat.pass_done) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.region_write = 1'b1;
				cmd.region_used  = !stat.req_free;
				res_d            = ST_OK;
				state_d          = S_DONE;
			end
			S_DONE: begin
				// hold the result until the output register frees up
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					cmd.code     = res_q;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_RESET;
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.load_out) out_valid_d = 1'b1;
		else if (!out_stall) out_valid_d = 1'b0;
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/pba_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_datapath
// Page table and region table memories, the scan counter with its registered
// read stage, the byte accumulators and the result register.
// ----------------------------------------------------------------------------
module pba_datapath #(
	parameter int PAGE_COUNT   = 64,
	parameter int PAGE_BYTES   = 1024,
	parameter int REGION_COUNT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pba_pkg::ADDR_W-1:0]    cfg_wdata,
	input  logic                          kind,
	input  logic [pba_pkg::SIZE_W-1:0]    byte_size,
	input  logic [pba_pkg::ADDR_W-1:0]    free_address,
	output logic [pba_pkg::ADDR_W-1:0]    region_address,
	output logic [pba_pkg::STAT_W-1:0]    status,
	input  pba_pkg::cmd_t                 cmd,
	output pba_pkg::stat_t                stat
);
	import pba_pkg::*;

	localparam int N    = (PAGE_COUNT > REGION_COUNT) ? PAGE_COUNT : REGION_COUNT;
	localparam int CW   = $clog2(N + 1);
	localparam int PW   = $clog2(PAGE_COUNT);
	localparam int RW   = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
	localparam int FBW  = $clog2(PAGE_COUNT * PAGE_BYTES + 1);
	localparam int CMPW = (FBW > SIZE_W) ? FBW : SIZE_W;
	localparam logic [SIZE_W-1:0] PB_SIZE = SIZE_W'(PAGE_BYTES);
	localparam logic [ADDR_W-1:0] PB_ADDR = ADDR_W'(PAGE_BYTES);
	localparam logic [FBW-1:0]    PB_FB   = FBW'(PAGE_BYTES);

	typedef struct packed {
		logic          used;
		logic [RW-1:0] owner;
	} page_ent_t;

	typedef struct packed {
		logic              used;
		logic [ADDR_W-1:0] base;
	} region_ent_t;

	page_ent_t   pg_mem [PAGE_COUNT];
	region_ent_t rg_mem [REGION_COUNT];

	// request and configuration
	logic [ADDR_W-1:0] base_q;
	logic              kind_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] faddr_q;

	// scan control
	pass_mode_t  mode_q;
	logic        run_q;
	logic [CW-1:0] cnt_q;
	logic        act_s1;
	logic [CW-1:0] idx_s1;
	page_ent_t   pg_rd_s1;
	region_ent_t rg_rd_s1;
	logic        done_q;

	// pass results
	logic              slot_found_q;
	logic [RW-1:0]     slot_q;
	logic [FBW-1:0]    fbytes_q;
	logic [SIZE_W-1:0] rem_q;
	logic              first_q;
	logic [ADDR_W-1:0] page_addr_q;
	logic [ADDR_W-1:0] addr_q;

	logic        in_page, in_region, last_idx;
	logic        pg_we;
	logic [PW-1:0] pg_waddr;
	page_ent_t   pg_wdata;
	logic        rg_we;
	logic [RW-1:0] rg_waddr;
	region_ent_t rg_wdata;
	logic        take_page, take_slot;

	assign in_page   = act_s1 && (idx_s1 < CW'(PAGE_COUNT));
	assign in_region = act_s1 && (idx_s1 < CW'(REGION_COUNT));
	assign last_idx  = (cnt_q == CW'(N - 1));

	always_comb begin
		take_page = 1'b0;
		take_slot = 1'b0;
		pg_we     = 1'b0;
		pg_waddr  = idx_s1[PW-1:0];
		pg_wdata  = '0;
		rg_we     = 1'b0;
		rg_waddr  = idx_s1[RW-1:0];
		rg_wdata  = '0;
		unique case (mode_q)
			PASS_CLEAR: begin
				pg_we = in_page;
				rg_we = in_region;
			end
			PASS_FIND: begin
				take_slot = in_region && !rg_rd_s1.used && !slot_found_q;
			end
			PASS_MATCH: begin
				take_slot = in_region && rg_rd_s1.used && !slot_found_q
					&& (rg_rd_s1.base == faddr_q);
			end
			PASS_CLAIM: begin
				take_page      = in_page && !pg_rd_s1.used && (rem_q != '0);
				pg_we          = take_page;
				pg_wdata.used  = 1'b1;
				pg_wdata.owner = slot_q;
			end
			PASS_RELEASE: begin
				pg_we          = in_page && pg_rd_s1.used && (pg_rd_s1.owner == slot_q);
				pg_wdata.used  = 1'b0;
				pg_wdata.owner = pg_rd_s1.owner;
			end
			default: ;
		endcase
		if (cmd.region_write) begin
			rg_we         = 1'b1;
			rg_waddr      = slot_q;
			rg_wdata.used = cmd.region_used;
			rg_wdata.base = addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pg_we) pg_mem[pg_waddr] <= pg_wdata;
		pg_rd_s1 <= pg_mem[cnt_q[PW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (rg_we) rg_mem[rg_waddr] <= rg_wdata;
		rg_rd_s1 <= rg_mem[cnt_q[RW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			mode_q       <= PASS_CLEAR;
			run_q        <= 1'b0;
			cnt_q        <= '0;
			act_s1       <= 1'b0;
			idx_s1       <= '0;
			done_q       <= 1'b0;
			slot_found_q <= 1'b0;
			first_q      <= 1'b0;
		end else begin
			if (cfg_we) base_q <= cfg_wdata;
			act_s1 <= run_q;
			idx_s1 <= cnt_q;
			done_q <= act_s1 && (idx_s1 == CW'(N - 1));
			if (cmd.pass_start) begin
				mode_q <= cmd.mode;
				run_q  <= 1'b1;
				cnt_q  <= '0;
				if (cmd.mode == PASS_FIND || cmd.mode == PASS_MATCH) slot_found_q <= 1'b0;
				first_q <= 1'b0;
			end else begin
				if (run_q) begin
					if (last_idx) run_q <= 1'b0;
					else cnt_q <= cnt_q + CW'(1);
				end
				if (take_slot) slot_found_q <= 1'b1;
				if (take_page) first_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			size_q  <= byte_size;
			faddr_q <= free_address;
		end
		if (cmd.pass_start) begin
			fbytes_q    <= '0;
			rem_q       <= size_q;
			page_addr_q <= base_q;
		end else begin
			if (act_s1) page_addr_q <= page_addr_q + PB_ADDR;
			if (take_slot) slot_q <= idx_s1[RW-1:0];
			if (mode_q == PASS_FIND && in_page && !pg_rd_s1.used)
				fbytes_q <= fbytes_q + PB_FB;
			if (take_page) begin
				// saturate the remaining byte count at zero
				rem_q <= (rem_q <= PB_SIZE) ? '0 : rem_q - PB_SIZE;
				if (!first_q) addr_q <= page_addr_q;
			end
		end
		if (cmd.load_out) begin
			status         <= cmd.code;
			region_address <= (cmd.code == ST_OK && kind_q == KIND_ALLOC) ? addr_q : '0;
		end
	end

	assign stat.pass_done  = done_q;
	assign stat.slot_found = slot_found_q;
	assign stat.pages_ok   = CMPW'(fbytes_q) >= CMPW'(size_q);
	assign stat.req_free   = (kind_q == KIND_FREE);
	assign stat.req_zero   = (size_q == '0);

endmodule

// ===== test/tb_page_bitmap_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_bitmap_allocator_core
// Self-checking bench for the page bitmap allocator. A directed table covers
// zero size, unknown frees, oversized and full-memory requests, scattered
// page claims, shared bases after a base change and address wrap. Random
// traffic follows: mostly allocations and frees of live regions, some noise,
// and a flood of one-page requests that runs the region table dry. Every
// request beat is run through a behavioral allocator model; every reply beat
// is checked against the oldest queued reply, from the table or the model.
// ----------------------------------------------------------------------------
module tb_page_bitmap_allocator_core;
	import pba_pkg::*;

	localparam int PAGE_COUNT   = 64;
	localparam int PAGE_BYTES   = 1024;
	localparam int REGION_COUNT = 64;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [STAT_W-1:0] st;
	} reply_t;

	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_op_t;

	typedef struct {
		row_op_t           op;
		logic              k;
		logic [SIZE_W-1:0] sz;
		logic [ADDR_W-1:0] val;
		bit                typed;
		reply_t            want;
	} dir_row_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_we       = 1'b0;
	logic [ADDR_W-1:0] cfg_wdata    = '0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic              kind         = KIND_ALLOC;
	logic [SIZE_W-1:0] byte_size    = '0;
	logic [ADDR_W-1:0] free_address = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [ADDR_W-1:0] region_address;
	logic [STAT_W-1:0] status;

	// allocator model state
	logic [ADDR_W-1:0] base_reg;
	bit                pg_used   [PAGE_COUNT];
	logic [5:0]        pg_owner  [PAGE_COUNT];
	bit                slot_live [REGION_COUNT];
	logic [ADDR_W-1:0] slot_base [REGION_COUNT];

	reply_t   pending_replies [$];
	dir_row_t dir_rows [$];
	int       fail_count  = 0;
	int       idle_in_pct = 0;
	int       stall_pct   = 0;

	page_bitmap_allocator_core #(
		.PAGE_COUNT  (PAGE_COUNT),
		.PAGE_BYTES  (PAGE_BYTES),
		.REGION_COUNT(REGION_COUNT)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.byte_size     (byte_size),
		.free_address  (free_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.region_address(region_address),
		.status        (status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("tb_page_bitmap_allocator_core failed");
		$finish;
	end

	function automatic reply_t serve_request(input logic k, input logic [SIZE_W-1:0] sz,
		input logic [ADDR_W-1:0] fa);
		reply_t r;
		int     need;
		int     free_pages;
		int     slot;
		bit     first;
		r.addr = '0;
		r.st   = ST_OK;
		slot   = -1;
		if (k == KIND_ALLOC) begin
			if (sz == '0) begin
				r.st = ST_ZERO;
				return r;
			end
			need = (int'(sz) + PAGE_BYTES - 1) / PAGE_BYTES;
			for (int i = 0; i < REGION_COUNT; i++)
				if (!slot_live[i] && slot < 0)
					slot = i;
			if (slot < 0) begin
				r.st = ST_NO_SLOT;
				return r;
			end
			free_pages = 0;
			for (int i = 0; i < PAGE_COUNT; i++)
				if (!pg_used[i])
					free_pages++;
			if (free_pages < need) begin
				r.st = ST_NO_PAGES;
				return r;
			end
			first = 1'b1;
			for (int i = 0; i < PAGE_COUNT && need > 0; i++) begin
				if (!pg_used[i]) begin
					pg_used[i]  = 1'b1;
					pg_owner[i] = 6'(slot);
					if (first) begin
						r.addr = base_reg + 32'(i * PAGE_BYTES);
						first  = 1'b0;
					end
					need--;
				end
			end
			slot_live[slot] = 1'b1;
			slot_base[slot] = r.addr;
		end else begin
			// lowest live slot wins when bases are shared
			for (int i = 0; i < REGION_COUNT; i++)
				if (slot_live[i] && slot_base[i] == fa && slot < 0)
					slot = i;
			if (slot < 0) begin
				r.st = ST_UNKNOWN;
				return r;
			end
			for (int i = 0; i < PAGE_COUNT; i++)
				if (pg_used[i] && pg_owner[i] == 6'(slot))
					pg_used[i] = 1'b0;
			slot_live[slot] = 1'b0;
		end
		return r;
	endfunction

	task automatic add_row(input row_op_t op, input logic k, input logic [SIZE_W-1:0] sz,
		input logic [ADDR_W-1:0] v, input bit typed, input logic [ADDR_W-1:0] ea,
		input logic [STAT_W-1:0] es);
		dir_row_t row;
		row.op      = op;
		row.k       = k;
		row.sz      = sz;
		row.val     = v;
		row.typed   = typed;
		row.want.addr = ea;
		row.want.st   = es;
		dir_rows.push_back(row);
	endtask

	task automatic send_req(input logic k, input logic [SIZE_W-1:0] sz,
		input logic [ADDR_W-1:0] fa, input bit typed, input reply_t typed_reply);
		reply_t predicted;
		while ($urandom_range(0, 99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		byte_size    <= sz;
		free_address <= fa;
		do @(posedge clk); while (in_stall);
		predicted = serve_request(k, sz, fa);
		pending_replies.push_back(typed ? typed_reply : predicted);
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
	endtask

	task automatic write_base(input logic [ADDR_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		base_reg = v;
	endtask

	task automatic pick_request(output logic k, output logic [SIZE_W-1:0] sz,
		output logic [ADDR_W-1:0] fa);
		int r;
		int start;
		int idx;
		bit found;
		r     = $urandom_range(0, 99);
		sz    = SIZE_W'($urandom);
		fa    = $urandom;
		found = 1'b0;
		start = $urandom_range(0, REGION_COUNT - 1);
		for (int i = 0; i < REGION_COUNT; i++) begin
			idx = (start + i) % REGION_COUNT;
			if (slot_live[idx] && !found) begin
				found = 1'b1;
				fa    = slot_base[idx];
			end
		end
		if (r < 38 && found) begin
			k = KIND_FREE;
		end else if (r < 45) begin
			// near miss or pure noise address
			k = KIND_FREE;
			if (found && r < 41)
				fa = fa + 32'($urandom_range(1, PAGE_BYTES));
			else
				fa = $urandom;
		end else begin
			k = KIND_ALLOC;
			case ($urandom_range(0, 9))
				0: sz = '0;
				1: sz = SIZE_W'($urandom);
				2: sz = SIZE_W'($urandom_range(1, 65536));
				default: sz = SIZE_W'($urandom_range(1, 4 * PAGE_BYTES));
			endcase
		end
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected reply beat: region_address %h status %0d",
						$realtime, region_address, status);
			end else begin
				want = pending_replies.pop_front();
				if (region_address !== want.addr || status !== want.st) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: reply mismatch: region_address %h (want %h), %s%0d (want %0d)",
							$realtime, region_address, want.addr, "status ", status, want.st);
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		logic              k;
		logic [SIZE_W-1:0] sz;
		logic [ADDR_W-1:0] fa;
		reply_t            none;
		none     = '0;
		base_reg = '0;
		foreach (pg_used[i]) begin
			pg_used[i]  = 1'b0;
			pg_owner[i] = '0;
		end
		foreach (slot_live[i]) begin
			slot_live[i] = 1'b0;
			slot_base[i] = '0;
		end

		add_row(ROW_CFG, KIND_ALLOC, '0, 32'h0000_0000, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_ALLOC, '0, '0, 1'b1, 32'd0, ST_ZERO);
		add_row(ROW_REQ, KIND_FREE, 17'h1FFFF, 32'd0, 1'b1, 32'd0, ST_UNKNOWN);
		add_row(ROW_REQ, KIND_FREE, '0, 32'hFFFF_FFFF, 1'b1, 32'd0, ST_UNKNOWN);
		add_row(ROW_REQ, KIND_ALLOC, 17'd1, '0, 1'b1, 32'd0, ST_OK);
		add_row(ROW_REQ, KIND_ALLOC, 17'd1024, '0, 1'b1, 32'd1024, ST_OK);
		add_row(ROW_REQ, KIND_ALLOC, 17'h1FFFF, '0, 1'b1, 32'd0, ST_NO_PAGES);
		add_row(ROW_REQ, KIND_ALLOC, 17'd65536, '0, 1'b1, 32'd0, ST_NO_PAGES);
		add_row(ROW_REQ, KIND_ALLOC, 17'd1025, '0, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_FREE, '0, 32'd1024, 1'b1, 32'd0, ST_OK);
		// reuse the hole at page 1, then skip the used pages beyond it
		add_row(ROW_REQ, KIND_ALLOC, 17'd3000, '0, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_FREE, '0, 32'd0, 1'b1, 32'd0, ST_OK);
		// shift the base so a new region lands on a live region's base
		add_row(ROW_CFG, KIND_ALLOC, '0, 32'd2048, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_ALLOC, 17'd1, '0, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_FREE, '0, 32'd2048, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_FREE, '0, 32'd2048, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_FREE, '0, 32'd2048, 1'b0, '0, ST_OK);
		// unaligned top base: addresses wrap
		add_row(ROW_CFG, KIND_ALLOC, '0, 32'hFFFF_FFFF, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_ALLOC, 17'd2048, '0, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_FREE, '0, 32'd1024, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_FREE, '0, 32'hFFFF_FFFF, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_ALLOC, 17'd65536, '0, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_ALLOC, 17'd1, '0, 1'b0, '0, ST_OK);
		add_row(ROW_REQ, KIND_FREE, '0, 32'hFFFF_FFFF, 1'b0, '0, ST_OK);

		idle_in_pct = 37;
		stall_pct   = 72;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[n]) begin
			if (dir_rows[n].op == ROW_CFG) begin
				drain_replies();
				write_base(dir_rows[n].val);
			end else begin
				send_req(dir_rows[n].k, dir_rows[n].sz, dir_rows[n].val, dir_rows[n].typed,
					dir_rows[n].want);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					idle_in_pct = 37;
					stall_pct   = 72;
				end
				1: begin
					idle_in_pct = 72;
					stall_pct   = 37;
				end
				default: begin
					idle_in_pct = 0;
					stall_pct   = 0;
				end
			endcase
			// hold the sender until every reply is back before touching the base
			drain_replies();
			case (ph)
				0: write_base($urandom & 32'hFFFF_FC00);
				1: write_base($urandom);
				default: write_base(32'hFFFF_F000);
			endcase
			repeat (250) begin
				pick_request(k, sz, fa);
				send_req(k, sz, fa, 1'b0, none);
			end
		end

		// release every live region, then flood with one-page requests
		drain_replies();
		for (int i = 0; i < REGION_COUNT; i++)
			if (slot_live[i])
				send_req(KIND_FREE, SIZE_W'($urandom), slot_base[i], 1'b0, none);
		repeat (100) begin
			pick_request(k, sz, fa);
			if ($urandom_range(0, 9) != 0) begin
				k  = KIND_ALLOC;
				sz = SIZE_W'($urandom_range(1, PAGE_BYTES));
			end
			send_req(k, sz, fa, 1'b0, none);
		end

		drain_replies();
		repeat (4 * PAGE_COUNT) @(posedge clk);
		if (pending_replies.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("tb_page_bitmap_allocator_core passed");
		else
			$display("tb_page_bitmap_allocator_core failed");
		$finish;
	end

endmodule
